/* hdl/bcpi_pkg.sv */
// ----------------------------------------------------------------------------
// Brake chopper PI control package
// Shared widths, limits, register indexes, datapath control types and the
// microcode table of the control sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpi_pkg;

    // Field and datapath widths.
    localparam int ADC_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int VOLT_W     = 16;
    localparam int PROD_W     = 32;
    localparam int TERM_W     = 28;
    localparam int INTEG_W    = 17;
    localparam int DUTY_W     = 16;
    localparam int CMP_W      = 10;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PC_W       = 4;

    // Default PWM period in counts.
    localparam int unsigned PWM_PERIOD_DEFAULT = 1023;

    // Integrator ceiling (1.0 in Q1.16) and duty ceiling (0.95 in Q0.16).
    localparam logic [INTEG_W-1:0] INTEG_MAX = 17'd65536;
    localparam logic [DUTY_W-1:0]  DUTY_MAX  = 16'd62259;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRAKE_ENABLE = 3'd0,
        REG_VBUS_PRESENT = 3'd1,
        REG_DIVIDER_GAIN = 3'd2,
        REG_TARGET_VOLTS = 3'd3,
        REG_PROP_GAIN    = 3'd4,
        REG_INTEG_GAIN   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic              brake_enable;
        logic              vbus_present;
        logic [GAIN_W-1:0] divider_gain;
        logic [VOLT_W-1:0] target_volts;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
    } cfg_t;

    // Datapath operations, one per microcode step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_V,
        OP_SAT_V,
        OP_SUB,
        OP_MUL_P,
        OP_LD_P,
        OP_MUL_I,
        OP_ACC_I,
        OP_ADD_D,
        OP_CLEAR,
        OP_MUL_C,
        OP_LD_C,
        OP_HOLD,
        OP_EMIT
    } dp_op_t;

    // Jump conditions: taken goes to the target, otherwise to the next step.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DISABLED,
        COND_NOT_ABOVE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t          op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Program step addresses.
    localparam logic [PC_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] STEP_MUL_V = 4'd1;
    localparam logic [PC_W-1:0] STEP_SAT_V = 4'd2;
    localparam logic [PC_W-1:0] STEP_SUB   = 4'd3;
    localparam logic [PC_W-1:0] STEP_MUL_P = 4'd4;
    localparam logic [PC_W-1:0] STEP_LD_P  = 4'd5;
    localparam logic [PC_W-1:0] STEP_MUL_I = 4'd6;
    localparam logic [PC_W-1:0] STEP_ACC_I = 4'd7;
    localparam logic [PC_W-1:0] STEP_ADD_D = 4'd8;
    localparam logic [PC_W-1:0] STEP_CLEAR = 4'd9;
    localparam logic [PC_W-1:0] STEP_MUL_C = 4'd10;
    localparam logic [PC_W-1:0] STEP_LD_C  = 4'd11;
    localparam logic [PC_W-1:0] STEP_HOLD  = 4'd12;
    localparam logic [PC_W-1:0] STEP_EMIT  = 4'd13;
    localparam logic [PC_W-1:0] STEP_LAST  = STEP_EMIT;

    // Control signals from the sequencer to the datapath.
    typedef struct packed {
        dp_op_t op;
        logic   in_take;
    } dp_ctrl_t;

    // Status flags from the datapath back to the sequencer.
    typedef struct packed {
        logic disabled;
        logic above;
    } dp_status_t;

    // Result registers of the datapath.
    typedef struct packed {
        logic [CMP_W-1:0]  compare_value;
        logic [DUTY_W-1:0] duty_fraction;
        logic              braking;
        logic              stepped;
    } dp_result_t;

    // Microcode program.
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT};
        case (pc)
            STEP_WAIT:  w = '{op: OP_LOAD,  cond: COND_NO_INPUT,  target: STEP_WAIT};
            STEP_MUL_V: w = '{op: OP_MUL_V, cond: COND_DISABLED,  target: STEP_HOLD};
            STEP_SAT_V: w = '{op: OP_SAT_V, cond: COND_NEVER,     target: STEP_WAIT};
            STEP_SUB:   w = '{op: OP_SUB,   cond: COND_NOT_ABOVE, target: STEP_CLEAR};
            STEP_MUL_P: w = '{op: OP_MUL_P, cond: COND_NEVER,     target: STEP_WAIT};
            STEP_LD_P:  w = '{op: OP_LD_P,  cond: COND_NEVER,     target: STEP_WAIT};
            STEP_MUL_I: w = '{op: OP_MUL_I, cond: COND_NEVER,     target: STEP_WAIT};
            STEP_ACC_I: w = '{op: OP_ACC_I, cond: COND_NEVER,     target: STEP_WAIT};
            STEP_ADD_D: w = '{op: OP_ADD_D, cond: COND_ALWAYS,    target: STEP_MUL_C};
            STEP_CLEAR: w = '{op: OP_CLEAR, cond: COND_NEVER,     target: STEP_WAIT};
            STEP_MUL_C: w = '{op: OP_MUL_C, cond: COND_NEVER,     target: STEP_WAIT};
            STEP_LD_C:  w = '{op: OP_LD_C,  cond: COND_ALWAYS,    target: STEP_EMIT};
            STEP_HOLD:  w = '{op: OP_HOLD,  cond: COND_NEVER,     target: STEP_WAIT};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY,  target: STEP_EMIT};
            default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,    target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/bcpi_if.sv */
// ----------------------------------------------------------------------------
// Brake chopper PI control channel interfaces
// Valid/ready channels for the ADC sample and for the control result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpi_sample_if
    import bcpi_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_volts;

    modport source (output valid, output adc_volts, input ready);
    modport sink   (input valid, input adc_volts, output ready);
endinterface

interface bcpi_result_if
    import bcpi_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMP_W-1:0]  compare_value;
    logic [DUTY_W-1:0] duty_fraction;
    logic              braking;
    logic              stepped;

    modport source (output valid, output compare_value, output duty_fraction,
                    output braking, output stepped, input ready);
    modport sink   (input valid, input compare_value, input duty_fraction,
                    input braking, input stepped, output ready);
endinterface

`default_nettype wire

/* hdl/bcpi_datapath.sv */
// ----------------------------------------------------------------------------
// Brake chopper PI control datapath
// One shared 16x16 multiplier, an adder/clamp unit and the working registers,
// driven one operation per cycle by the microcode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpi_datapath
    import bcpi_pkg::*;
#(
    parameter int unsigned PWM_PERIOD = PWM_PERIOD_DEFAULT
) (
    input  wire              clk,
    input  wire              rst_n,
    input  cfg_t             cfg,
    input  dp_ctrl_t         ctrl,
    input  wire  [ADC_W-1:0] adc_volts,
    output dp_status_t       status,
    output dp_result_t       result
);

    localparam logic [PERIOD_W-1:0] PERIOD_VAL = PERIOD_W'(PWM_PERIOD);

    logic [ADC_W-1:0]   adc_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [VOLT_W-1:0]  vbus_reg;
    logic [VOLT_W-1:0]  err_reg;
    logic [TERM_W-1:0]  pterm_reg;
    logic [INTEG_W-1:0] integ_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic [CMP_W-1:0]   compare_reg;
    logic               braking_reg;
    logic               stepped_reg;

    logic [15:0]        mul_a;
    logic [15:0]        mul_b;
    logic [TERM_W:0]    isum;
    logic [TERM_W:0]    dsum;
    logic [VOLT_W-1:0]  vbus_sat;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.op)
            OP_MUL_V:
            begin
                mul_a = cfg.vbus_present ? adc_reg : '0;
                mul_b = cfg.divider_gain;
            end
            OP_MUL_P:
            begin
                mul_a = err_reg;
                mul_b = cfg.prop_gain;
            end
            OP_MUL_I:
            begin
                mul_a = err_reg;
                mul_b = cfg.integ_gain;
            end
            OP_MUL_C:
            begin
                mul_a = duty_reg;
                mul_b = PERIOD_VAL;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Saturation of the scaled bus voltage and the two clamped sums.
    assign vbus_sat = (|prod_reg[PROD_W-1:30]) ? '1 : prod_reg[29:14];
    assign isum     = (TERM_W+1)'(integ_reg) + {1'b0, prod_reg[PROD_W-1:4]};
    assign dsum     = {1'b0, pterm_reg} + (TERM_W+1)'(integ_reg);

    // Controller state: integrator, held duty and held compare count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg   <= '0;
            duty_reg    <= '0;
            compare_reg <= '0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_ACC_I:
                begin
                    integ_reg <= (isum > (TERM_W+1)'(INTEG_MAX)) ? INTEG_MAX
                                                                 : isum[INTEG_W-1:0];
                end
                OP_ADD_D:
                begin
                    duty_reg <= (dsum > (TERM_W+1)'(DUTY_MAX)) ? DUTY_MAX
                                                               : dsum[DUTY_W-1:0];
                end
                OP_CLEAR:
                begin
                    integ_reg <= '0;
                    duty_reg  <= '0;
                end
                OP_LD_C:
                begin
                    compare_reg <= prod_reg[16+CMP_W-1:16];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers, which need no reset.
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (ctrl.in_take)
                begin
                    adc_reg <= adc_volts;
                end
            end
            OP_MUL_V:
            begin
                prod_reg    <= mul_a * mul_b;
                stepped_reg <= 1'b1;
            end
            OP_MUL_P, OP_MUL_I, OP_MUL_C:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_SAT_V:
            begin
                vbus_reg <= vbus_sat;
            end
            OP_SUB:
            begin
                err_reg     <= vbus_reg - cfg.target_volts;
                braking_reg <= vbus_reg > cfg.target_volts;
            end
            OP_LD_P:
            begin
                pterm_reg <= prod_reg[PROD_W-1:4];
            end
            OP_HOLD:
            begin
                braking_reg <= 1'b0;
                stepped_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign status.disabled = !cfg.brake_enable || (cfg.target_volts == '0);
    assign status.above    = vbus_reg > cfg.target_volts;

    assign result.compare_value = compare_reg;
    assign result.duty_fraction = duty_reg;
    assign result.braking       = braking_reg;
    assign result.stepped       = stepped_reg;

endmodule

`default_nettype wire

/* hdl/brake_chopper_pi_control_core.sv */
// ----------------------------------------------------------------------------
// Brake chopper PI control core
// Microcoded PI controller that turns bus-voltage samples into a PWM duty.
// ----------------------------------------------------------------------------
// Usage: sample_in carries one ADC divider reading per transaction; result_out
// returns exactly one transaction per sample with the compare count, the duty
// in Q0.16, and the braking and stepped flags. The cfg_we/cfg_index/cfg_data
// port writes the six registers; write them only while the block is idle.
// Each sample runs a short microcode program over one shared 16x16
// multiplier, one step per clock while the output is not stalled. Above
// target the steps are scale, saturate, subtract, proportional multiply and
// load, integral multiply and accumulate, duty sum, compare multiply and
// load, then emit; at or below target the subtract is followed by a clear
// of the integrator and duty and then the compare steps; when the block is
// disabled or the target is zero the scaling step goes to hold, then emit.
// sample_in.ready is high only in the wait step, so a new sample can be taken
// the cycle after the previous result was loaded, while that result can
// still be waiting in the output register. If the receiver stalls with a
// result pending, the program holds in its emit step until the slot frees.
// Reset returns the cfg registers to their defaults and clears the integrator,
// the held duty and the held compare count; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module brake_chopper_pi_control_core
    import bcpi_pkg::*;
#(
    parameter int unsigned PWM_PERIOD = PWM_PERIOD_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    bcpi_sample_if.sink          sample_in,
    bcpi_result_if.source        result_out,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data
);

    cfg_t            cfg_reg;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    dp_result_t      out_data_reg;

    uword_t          uword;
    dp_ctrl_t        ctrl;
    dp_status_t      status;
    dp_result_t      result;
    logic            in_take;
    logic            out_busy;
    logic            emit_fire;
    logic            jump;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brake_enable <= 1'b0;
            cfg_reg.vbus_present <= 1'b0;
            cfg_reg.divider_gain <= 16'd256;
            cfg_reg.target_volts <= '0;
            cfg_reg.prop_gain    <= '0;
            cfg_reg.integ_gain   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BRAKE_ENABLE: cfg_reg.brake_enable <= cfg_data[0];
                REG_VBUS_PRESENT: cfg_reg.vbus_present <= cfg_data[0];
                REG_DIVIDER_GAIN: cfg_reg.divider_gain <= cfg_data;
                REG_TARGET_VOLTS: cfg_reg.target_volts <= cfg_data;
                REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_data;
                REG_INTEG_GAIN:   cfg_reg.integ_gain   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Microcode fetch and handshake qualifiers.
    assign uword     = ucode_rom(pc_reg);
    assign in_take   = (uword.op == OP_LOAD) && sample_in.valid;
    assign out_busy  = out_valid_reg && !result_out.ready;
    assign emit_fire = (uword.op == OP_EMIT) && !out_busy;

    // Jump condition evaluation.
    always_comb
    begin
        unique case (uword.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_INPUT:  jump = !sample_in.valid;
            COND_DISABLED:  jump = status.disabled;
            COND_NOT_ABOVE: jump = !status.above;
            COND_OUT_BUSY:  jump = out_busy;
            default:        jump = 1'b1;
        endcase
    end

    // Step counter next value.
    always_comb
    begin
        priority if (jump)
            pc_next = uword.target;
        else if (pc_reg == STEP_LAST)
            pc_next = STEP_WAIT;
        else
            pc_next = pc_reg + 1'b1;
    end

    // Output slot occupancy.
    always_comb
    begin
        priority if (emit_fire)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign ctrl.op      = uword.op;
    assign ctrl.in_take = in_take;

    bcpi_datapath #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .adc_volts (sample_in.adc_volts),
        .status    (status),
        .result    (result)
    );

    assign sample_in.ready          = (uword.op == OP_LOAD);
    assign result_out.valid         = out_valid_reg;
    assign result_out.compare_value = out_data_reg.compare_value;
    assign result_out.duty_fraction = out_data_reg.duty_fraction;
    assign result_out.braking       = out_data_reg.braking;
    assign result_out.stepped       = out_data_reg.stepped;

    // An accepted sample always starts the program at the scaling step.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.valid && sample_in.ready |=> pc_reg == STEP_MUL_V)
        else $error("accepted sample did not start the program");

    // A free output slot in the emit step always yields a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == STEP_EMIT && !out_busy |=> out_valid_reg)
        else $error("emit step did not load the result slot");

    // A pending result never carries a duty above the ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> result_out.duty_fraction <= DUTY_MAX)
        else $error("duty above ceiling");

    // A result from a skipped step never reports braking.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.stepped |-> !result_out.braking)
        else $error("braking reported without a control step");

    // No sample is taken while the output slot is still being loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == STEP_EMIT |-> !sample_in.ready)
        else $error("input ready during emit step");

endmodule

`default_nettype wire
